// File: design/assert_macros.svh
// assertion macros shared by the multiply/divide register unit
// no dependencies; the assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define MDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define MDR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MDR_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: design/mdr_pkg.sv
// shared types and constants of the multiply/divide register unit
// no dependencies; imported by mdr_mul, mdr_div and the top level
package mdr_pkg;

    // request kinds carried on tuser
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // register map of the math window
    localparam logic [3:0] REG_MUL_HI = 4'd5;
    localparam logic [3:0] REG_DIV_HI = 4'd7;
    localparam logic [3:0] REG_MODE   = 4'd14;
    localparam logic [3:0] REG_STATUS = 4'd15;

    // status and mode bits
    localparam logic [7:0] BUSY_BIT        = 8'h80;
    localparam logic [7:0] BUSY_CLEAR_MASK = 8'h7f;
    localparam int         MODE_SIGNED_BIT = 0;

    // number of operand and result bytes
    localparam int NUM_OPERANDS = 8;
    localparam int NUM_RESULTS  = 6;

    // launch control from the register window to an arithmetic unit
    typedef struct packed {
        logic start;
        logic signed_mode;
    } op_ctl_t;

endpackage

// File: design/mul_div_register_unit.sv
// top level: byte-wide register window with bit-serial multiply and divide units
// depends on mdr_pkg, mdr_mul, mdr_div and assert_macros.svh
//
//  channel | direction | tdata (low bit up)                  | tuser
//  s_*     | in        | reg_index[3:0], write_data[11:4]    | req_type
//  m_*     | out       | read_data[7:0]                      | -
//
// reads and plain writes: the result is registered into the output register in the cycle after the transfer
// multiply start (write to register 5): result from the 16-step serial multiplier
// divide start (write to register 7): quotient and remainder from the 32-step restoring divider
// one access at a time; the next is taken once the result is delivered or leaving
// m_tready low stalls the output register and holds off new input transfers
// asynchronous reset clears all top-level registers to zero, unsigned mode, status clear
`include "assert_macros.svh"

module mul_div_register_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reg_index[3:0], write_data[11:4], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // read_data[7:0]
);
    import mdr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

    state_t      state_reg;
    logic        op_div_reg;
    logic [7:0]  operand_reg [NUM_OPERANDS];
    logic [7:0]  result_reg [NUM_RESULTS];
    logic [7:0]  mode_reg;
    logic [7:0]  status_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic        accept;
    logic        is_write;
    logic [3:0]  reg_index;
    logic [7:0]  write_data;
    logic [7:0]  read_byte;
    logic        start_wr;
    logic        status_rd;
    logic        unit_done;
    logic        out_stall;
    logic        out_load;
    op_ctl_t     mul_ctl;
    op_ctl_t     div_ctl;
    logic        mul_done;
    logic        div_done;
    logic [31:0] product;
    logic [31:0] quotient;
    logic [15:0] remainder;

    // input field unpacking and handshake
    assign reg_index  = s_tdata[3:0];
    assign write_data = s_tdata[11:4];
    assign is_write   = (s_tuser == REQ_WRITE);
    assign out_stall  = m_tvalid_reg && !m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && !out_stall;
    assign accept     = s_tvalid && s_tready;

    // access kinds and output register load
    assign start_wr  = accept && is_write && (reg_index == REG_MUL_HI || reg_index == REG_DIV_HI);
    assign status_rd = accept && !is_write && (reg_index == REG_STATUS);
    assign unit_done = mul_done || div_done;
    assign out_load  = (state_reg == ST_IDLE) ? (accept && !start_wr)
                                              : ((state_reg == ST_WAIT) && unit_done);

    // register read mux
    always_comb
    begin
        if (!reg_index[3])
            read_byte = operand_reg[reg_index[2:0]];
        else if (reg_index == REG_MODE)
            read_byte = mode_reg;
        else if (reg_index == REG_STATUS)
            read_byte = status_reg;
        else
            read_byte = result_reg[reg_index[2:0]];
    end

    // launch control to the arithmetic units
    assign mul_ctl.start       = (state_reg == ST_LAUNCH) && !op_div_reg;
    assign mul_ctl.signed_mode = mode_reg[MODE_SIGNED_BIT];
    assign div_ctl.start       = (state_reg == ST_LAUNCH) && op_div_reg;
    assign div_ctl.signed_mode = mode_reg[MODE_SIGNED_BIT];

    mdr_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (mul_ctl),
        .multiplicand ({operand_reg[1], operand_reg[0]}),
        .multiplier   ({operand_reg[5], operand_reg[4]}),
        .done         (mul_done),
        .product      (product)
    );

    mdr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  ({operand_reg[3], operand_reg[2], operand_reg[1], operand_reg[0]}),
        .divisor   ({operand_reg[7], operand_reg[6]}),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // access sequencer, register window and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_div_reg   <= 1'b0;
            mode_reg     <= 8'd0;
            status_reg   <= 8'd0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 8'd0;
            for (int i = 0; i < NUM_OPERANDS; i++)
                operand_reg[i] <= 8'd0;
            for (int i = 0; i < NUM_RESULTS; i++)
                result_reg[i] <= 8'd0;
        end
        else
        begin
            // output valid: set on a new result, cleared once taken
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_write)
                        begin
                            if (!reg_index[3])
                                operand_reg[reg_index[2:0]] <= write_data;
                            else if (reg_index == REG_MODE)
                            begin
                                for (int i = 0; i < NUM_OPERANDS; i++)
                                    operand_reg[i] <= 8'd0;
                                for (int i = 0; i < NUM_RESULTS; i++)
                                    result_reg[i] <= 8'd0;
                                mode_reg <= write_data;
                            end
                            if (start_wr)
                            begin
                                op_div_reg <= (reg_index == REG_DIV_HI);
                                state_reg  <= ST_LAUNCH;
                            end
                            else
                            begin
                                m_tdata_reg  <= 8'd0;
                            end
                        end
                        else
                        begin
                            m_tdata_reg  <= read_byte;
                            if (reg_index == REG_STATUS)
                                status_reg <= status_reg & BUSY_CLEAR_MASK;
                        end
                    end
                end
                ST_LAUNCH:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (unit_done)
                    begin
                        result_reg[0] <= mul_done ? product[7:0]   : quotient[7:0];
                        result_reg[1] <= mul_done ? product[15:8]  : quotient[15:8];
                        result_reg[2] <= mul_done ? product[23:16] : quotient[23:16];
                        result_reg[3] <= mul_done ? product[31:24] : quotient[31:24];
                        if (div_done)
                        begin
                            result_reg[4] <= remainder[7:0];
                            result_reg[5] <= remainder[15:8];
                        end
                        status_reg   <= BUSY_BIT;
                        m_tdata_reg  <= 8'd0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks on sequencing
    `MDR_NEVER(a_ready_stalled, clk, rst_n, s_tready && out_stall, "ready while stalled")
    `MDR_ASSERT(a_done_wait, clk, rst_n, unit_done |-> (state_reg == ST_WAIT), "done outside wait")
    `MDR_NEVER(a_one_unit, clk, rst_n, mul_done && div_done, "both units done")
    `MDR_ASSERT(a_start_launch, clk, rst_n, start_wr |=> (state_reg == ST_LAUNCH), "missed launch")
    `MDR_ASSERT(a_status_clear, clk, rst_n, status_rd |=> !status_reg[7], "busy left set")

endmodule

// File: design/mdr_mul.sv
// bit-serial 16x16 multiplier, signed or unsigned, one multiplier bit per cycle
// depends on mdr_pkg for the launch control struct
module mdr_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  mdr_pkg::op_ctl_t ctl,
    input  logic [15:0]     multiplicand,
    input  logic [15:0]     multiplier,
    output logic            done,
    output logic [31:0]     product
);
    import mdr_pkg::*;

    logic        run_reg, run_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] mcand_reg, mcand_next;
    logic [31:0] prod_reg, prod_next;
    logic [16:0] partial;
    logic        a_neg;
    logic        b_neg;

    // add the multiplicand into the upper half when the low multiplier bit is set
    assign partial = {1'b0, prod_reg[31:16]} + (prod_reg[0] ? {1'b0, mcand_reg} : 17'd0);
    assign a_neg   = ctl.signed_mode & multiplicand[15];
    assign b_neg   = ctl.signed_mode & multiplier[15];

    // step sequencing
    always_comb
    begin
        run_next   = run_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        if (ctl.start)
        begin
            run_next   = 1'b1;
            cnt_next   = 4'hf;
            neg_next   = a_neg ^ b_neg;
            mcand_next = a_neg ? (16'd0 - multiplicand) : multiplicand;
            prod_next  = {16'd0, b_neg ? (16'd0 - multiplier) : multiplier};
        end
        else if (run_reg)
        begin
            prod_next = {partial, prod_reg[15:1]};
            cnt_next  = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // apply the sign of the product
            prod_next = neg_reg ? (32'd0 - prod_reg) : prod_reg;
            done_next = 1'b1;
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// File: design/mdr_div.sv
// bit-serial restoring 32/16 divider, signed or unsigned, one quotient bit per cycle
// depends on mdr_pkg for the launch control struct
module mdr_div (
    input  logic            clk,
    input  logic            rst_n,
    input  mdr_pkg::op_ctl_t ctl,
    input  logic [31:0]     dividend,
    input  logic [15:0]     divisor,
    output logic            done,
    output logic [31:0]     quotient,
    output logic [15:0]     remainder
);
    import mdr_pkg::*;

    logic        run_reg, run_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        zero_reg, zero_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [15:0] lo_reg, lo_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [16:0] rem_shift;
    logic [17:0] diff;
    logic        fits;
    logic        d_neg;
    logic        s_neg;

    // trial subtraction of the divisor from the shifted partial remainder
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = ~diff[17];
    assign d_neg     = ctl.signed_mode & dividend[31];
    assign s_neg     = ctl.signed_mode & divisor[15];

    // step sequencing
    always_comb
    begin
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        negq_next = negq_reg;
        negr_next = negr_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (ctl.start)
        begin
            run_next  = 1'b1;
            cnt_next  = 5'd31;
            zero_next = (divisor == 16'd0);
            negq_next = d_neg ^ s_neg;
            negr_next = d_neg;
            lo_next   = dividend[15:0];
            quo_next  = d_neg ? (32'd0 - dividend) : dividend;
            dvs_next  = s_neg ? (16'd0 - divisor) : divisor;
            rem_next  = 16'd0;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[30:0], fits};
            rem_next = fits ? diff[15:0] : rem_shift[15:0];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // divide by zero keeps the low dividend half as remainder
            if (zero_reg)
            begin
                quo_next = 32'd0;
                rem_next = lo_reg;
            end
            else
            begin
                quo_next = negq_reg ? (32'd0 - quo_reg) : quo_reg;
                rem_next = negr_reg ? (16'd0 - rem_reg) : rem_reg;
            end
            done_next = 1'b1;
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
        dvs_reg  <= dvs_next;
        lo_reg   <= lo_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
